>>> sv/psf_pkg.sv
package psf_pkg;

   // Default sizing
   localparam int MAX_PRIMES_DEF = 64;
   localparam int VALUE_BITS_DEF = 16;

   // Fixed width of the value and prime_value fields on the ports
   localparam int FIELD_BITS = 16;

   // Address width for a store of the given depth (at least one bit)
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;    // capture the accepted item, rewind the table index
      logic start_read;   // read the table entry at the current index
      logic load_div;     // take the read prime as divisor, start the remainder
      logic div_step;     // one restoring remainder step
      logic next_index;   // advance to the next stored prime
      logic emit;         // write the result register, store the prime if room
      logic clear_count;  // end of item: clear the table if it was marked last
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic below_two;    // value is zero or one
      logic count_zero;   // table is empty
      logic div_done;     // final remainder step in progress
      logic rem_zero;     // remainder is zero: value divisible
      logic index_last;   // current index is the last stored prime
      logic out_free;     // result register can take a new item this cycle
   } status_type;

endpackage

>>> sv/psf_ram.sv
module psf_ram
   import psf_pkg::*;
#(
   parameter int WIDTH = VALUE_BITS_DEF,
   parameter int DEPTH = MAX_PRIMES_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [addr_bits(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]            wr_data,
   input  logic                        rd_en,
   input  logic [addr_bits(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/psf_datapath.sv
module psf_datapath
   import psf_pkg::*;
#(
   parameter int MAX_PRIMES = MAX_PRIMES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [FIELD_BITS-1:0] req_value,
   input  logic                  req_last,
   input  cmd_type               cmd,
   output status_type            stat,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [FIELD_BITS-1:0] rsp_prime_value,
   output logic                  rsp_table_full
);

   localparam int W  = VALUE_BITS;
   localparam int AW = addr_bits(MAX_PRIMES);
   localparam int CW = $clog2(MAX_PRIMES + 1);
   localparam int SW = $clog2(W);

   logic [W-1:0]            value_ff;
   logic                    last_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           index_ff;
   logic [W-1:0]            divisor_ff;
   logic [W-1:0]            shreg_ff;
   logic [W-1:0]            rem_ff, rem_in;
   logic [SW-1:0]           step_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0]   prime_value_ff;
   logic                    table_full_ff;

   logic [31:0]             value_ext;
   logic [31:0]             prime_ext;
   logic [W:0]              trial;
   logic                    count_full;
   logic                    ram_wr_en;
   logic [W-1:0]            ram_rd_data;

   // low VALUE_BITS of the value field, zero extended if wider
   assign value_ext  = {16'd0, req_value};
   assign prime_ext  = 32'(value_ff);
   assign count_full = (count_ff == CW'(MAX_PRIMES));
   assign ram_wr_en  = cmd.emit && !count_full;

   // restoring remainder: shift in one value bit, subtract if it fits
   assign trial = {rem_ff, shreg_ff[W-1]};
   always_comb begin
      if (trial >= {1'b0, divisor_ff}) begin
         rem_in = W'(trial - {1'b0, divisor_ff});
      end else begin
         rem_in = trial[W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ram_wr_en) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.clear_count && last_ff) begin
         count_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         value_ff <= value_ext[W-1:0];
         last_ff  <= req_last;
      end
      if (cmd.load_item) begin
         index_ff <= '0;
      end else if (cmd.next_index) begin
         index_ff <= index_ff + AW'(1);
      end
      if (cmd.load_div) begin
         divisor_ff <= ram_rd_data;
         shreg_ff   <= value_ff;
         rem_ff     <= '0;
         step_ff    <= '0;
      end else if (cmd.div_step) begin
         shreg_ff <= {shreg_ff[W-2:0], 1'b0};
         rem_ff   <= rem_in;
         step_ff  <= step_ff + SW'(1);
      end
      if (cmd.emit) begin
         prime_value_ff <= prime_ext[FIELD_BITS-1:0];
         table_full_ff  <= count_full;
      end
   end

   psf_ram #(
      .WIDTH (W),
      .DEPTH (MAX_PRIMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_en   (cmd.start_read),
      .rd_addr (index_ff),
      .rd_data (ram_rd_data)
   );

   assign stat.below_two  = (value_ff[W-1:1] == '0);
   assign stat.count_zero = (count_ff == '0);
   assign stat.div_done   = (step_ff == SW'(W - 1));
   assign stat.rem_zero   = (rem_ff == '0);
   assign stat.index_last = ((CW'(index_ff) + CW'(1)) == count_ff);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = prime_value_ff;
   assign rsp_table_full  = table_full_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_PRIMES))
      else $error("prime count above table depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid_ff && prime_value_ff == $past(prime_ext[FIELD_BITS-1:0])))
      else $error("emitted item not presented");

   a_store_prime: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (value_ff[W-1:1] != '0))
      else $error("zero or one stored as prime");
`endif

endmodule

>>> sv/psf_ctrl.sv
module psf_ctrl
   import psf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_CHECK,
      ST_PRIME,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.load_item = 1'b1;
               state_in      = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (stat.below_two) begin
               state_in = ST_DONE;
            end else if (stat.count_zero) begin
               state_in = ST_PRIME;
            end else begin
               cmd.start_read = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         ST_READ: begin
            cmd.start_read = 1'b1;
            state_in       = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.rem_zero) begin
               state_in = ST_DONE;
            end else if (stat.index_last) begin
               state_in = ST_PRIME;
            end else begin
               cmd.next_index = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_PRIME: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.clear_count = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = stall_ff;

`ifndef SYNTHESIS
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE))
      else $error("item accepted while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("not busy after accept");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("emit without room in result register");
`endif

endmodule

>>> sv/prime_sieve_filter_unit.sv
// Prime sieve filter. Integers arrive on the req_ channel, normally ascending
// from 2; each one is tested against the primes stored so far. An item that
// no stored prime divides comes out on the rsp_ channel and is appended to
// the table; items that are divisible, and the values zero and one, give no
// result. Once the table holds MAX_PRIMES entries a new prime is still sent,
// with rsp_table_full set, but is not stored. An item with req_last set ends
// the stream: the table is emptied after that item is handled. Only the low
// VALUE_BITS bits of req_value are used. One item is in work at a time. An
// item's time grows with the number of stored primes tested before one
// divides it (all of them for a prime), and is set by the serial remainder
// unit, which takes one value bit per cycle, and by the single read port of
// the prime table. A finished result waits in an output register, so the
// next item is taken while the result is stalled; a prime that finds that
// register still full waits for it.
module prime_sieve_filter_unit
   import psf_pkg::*;
#(
   parameter int MAX_PRIMES = MAX_PRIMES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FIELD_BITS-1:0] req_value,
   input  logic                  req_last,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FIELD_BITS-1:0] rsp_prime_value,
   output logic                  rsp_table_full
);

   cmd_type    cmd;
   status_type stat;

   // sequencer: walks the table, runs the remainder steps, emits
   psf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // item registers, remainder unit, prime table, result register
   psf_datapath #(
      .MAX_PRIMES (MAX_PRIMES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .req_last        (req_last),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_prime_value (rsp_prime_value),
      .rsp_table_full  (rsp_table_full)
   );

endmodule

>>> tb/prime_sieve_checker.sv
`timescale 1ns / 1ps

module prime_sieve_checker
   import psf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [FIELD_BITS-1:0] req_value,
   input  logic                  req_last,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [FIELD_BITS-1:0] rsp_prime_value,
   input  logic                  rsp_table_full,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam logic [FIELD_BITS-1:0] VALUE_MASK =
      FIELD_BITS'((64'd1 << VALUE_BITS_DEF) - 64'd1);
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [FIELD_BITS-1:0] prime_value;
      logic                  table_full;
   } prime_result_type;

   logic [FIELD_BITS-1:0] known_primes [MAX_PRIMES_DEF];
   int unsigned           known_count;
   prime_result_type      expected_primes [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      known_count    = 0;
   end

   // Trial division against the primes found so far in this stream.
   task automatic sieve_item(input logic [FIELD_BITS-1:0] value, input logic last);
      logic [FIELD_BITS-1:0] v;
      logic                  divisible;
      prime_result_type      found;
      v = value & VALUE_MASK;
      divisible = 1'b0;
      for (int i = 0; i < known_count; i++)
         if (v % known_primes[i] == 0) divisible = 1'b1;
      if (v >= 2 && !divisible) begin
         found.prime_value = v;
         if (known_count < MAX_PRIMES_DEF) begin
            known_primes[known_count] = v;
            known_count++;
            found.table_full = 1'b0;
         end else begin
            found.table_full = 1'b1;
         end
         expected_primes.push_back(found);
         pending_count++;
      end
      if (last) known_count = 0;
   endtask

   always @(posedge clock) begin
      prime_result_type want;
      if (reset) begin
         expected_primes.delete();
         known_count   = 0;
         pending_count = 0;
      end else begin
         // result first: it always belongs to an item taken at an earlier edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_primes.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("unexpected result: prime_value %0d table_full %0b",
                           rsp_prime_value, rsp_table_full);
               mismatch_count++;
            end else begin
               want = expected_primes.pop_front();
               pending_count--;
               if (rsp_prime_value !== want.prime_value ||
                   rsp_table_full !== want.table_full) begin
                  if (mismatch_count < MAX_REPORTS)
                     $display("wrong result: expected prime_value %0d table_full %0b, got %0d %0b",
                              want.prime_value, want.table_full,
                              rsp_prime_value, rsp_table_full);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) sieve_item(req_value, req_last);
      end
   end

endmodule

>>> tb/tb_prime_sieve_filter_unit.sv
`timescale 1ns / 1ps

module tb_prime_sieve_filter_unit;
   import psf_pkg::*;

   // Worst item: every stored prime tested.
   localparam int ITEM_CYCLES  = 4 + MAX_PRIMES_DEF * (VALUE_BITS_DEF + 3);
   localparam int DRAIN_CYCLES = 2 * ITEM_CYCLES;
   localparam int CYCLE_LIMIT  = 6_000_000;
   localparam int ITEM_TARGET  = 1200;
   // 2..331 holds 67 primes, so a long stream overflows the table
   localparam int LONG_STREAM  = 330;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FIELD_BITS-1:0] req_value = '0;
   logic                  req_last  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [FIELD_BITS-1:0] rsp_prime_value;
   logic                  rsp_table_full;

   int mismatch_count;
   int pending_count;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   prime_sieve_filter_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_value (rsp_prime_value),
      .rsp_table_full  (rsp_table_full)
   );

   prime_sieve_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_value (rsp_prime_value),
      .rsp_table_full  (rsp_table_full),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   // Hang guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver backpressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Drive one item. Starts at the next falling edge, ends at the rising edge
   // where the item is taken. Valid is only lowered when a gap is drawn, so
   // back-to-back items keep valid high without a glitch.
   task automatic send_item(input logic [FIELD_BITS-1:0] value, input logic last);
      int gap;
      gap = 0;
      while (gap < 50 && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last  <= last;
      do @(posedge clock); while (req_stall);
      if (value >= 2) items_sent++;
   endtask

   // Stop sending and let every predicted prime come out.
   task automatic drain_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Off-stream value: repeat, descending, zero/one or anything in 16 bits.
   function automatic logic [FIELD_BITS-1:0] stray_value(input logic [FIELD_BITS-1:0] v);
      case ($urandom_range(3))
         0:       return FIELD_BITS'($urandom);
         1:       return FIELD_BITS'($urandom_range(1, 0));
         2:       return v - 1'b1;
         default: return FIELD_BITS'($urandom_range(v, 0));
      endcase
   endfunction

   // Well-formed stream 2, 3, 4, ... closed by last, with some stray items
   // mixed in to disturb the table.
   task automatic send_stream(input int length, input int stray_pct);
      logic [FIELD_BITS-1:0] v;
      for (int n = 0; n < length; n++) begin
         v = FIELD_BITS'(n + 2);
         if ($urandom_range(99) < stray_pct) send_item(stray_value(v), 1'b0);
         send_item(v, n == length - 1);
      end
   endtask

   initial begin
      int seq_count;
      int long_runs;
      int burst_len;
      seq_count = 0;
      long_runs = 0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // sender idles 22%, receiver 51%
      send_idle_pct = 22;
      recv_idle_pct = 51;

      // --- directed ---
      send_item(16'd0, 1'b0);         // zero: dropped, not stored
      send_item(16'd1, 1'b0);         // one: dropped, not stored
      send_item(16'd2, 1'b0);         // first prime into empty table
      send_item(16'd3, 1'b0);
      send_item(16'd4, 1'b0);         // composite
      send_item(16'd5, 1'b0);
      send_item(16'd3, 1'b0);         // repeat of a stored prime
      send_item(16'd2, 1'b0);         // descending, equal to stored
      send_item(16'd25, 1'b0);
      send_item(16'd7, 1'b0);
      send_item(16'd65535, 1'b0);     // all ones, divisible by 3
      send_item(16'd65521, 1'b0);     // largest 16-bit prime
      send_item(16'd32768, 1'b0);     // top bit only
      send_item(16'd9, 1'b1);         // last on a dropped item still clears
      send_item(16'd1, 1'b1);         // last on a value below two, empty table
      send_item(16'd4, 1'b0);         // empty table: 4 passes
      send_item(16'd8, 1'b0);
      send_item(16'd6, 1'b0);
      send_item(16'd65521, 1'b0);
      send_item(16'd65535, 1'b1);     // passes 4, 6 and 65521 in the table, then clear
      send_item(16'hAAAA, 1'b0);
      send_item(16'h5555, 1'b1);

      // hold off until the block has delivered everything
      drain_results();

      // --- random ---
      while (items_sent < ITEM_TARGET) begin
         if (items_sent < 400) begin
            send_idle_pct = 22;
            recv_idle_pct = 51;
         end else if (items_sent < 800) begin
            send_idle_pct = 51;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         if (seq_count == 0 || (long_runs < 2 && items_sent >= 850)) begin
            // long stream fills the table and runs past it
            send_stream(LONG_STREAM, 3);
            long_runs++;
         end else if ($urandom_range(99) < 75) begin
            send_stream($urandom_range(60, 3), 8);
         end else begin
            // noise burst: arbitrary values, last now and then
            burst_len = $urandom_range(6, 1);
            repeat (burst_len)
               send_item(($urandom_range(3) == 0) ? FIELD_BITS'($urandom)
                                                  : FIELD_BITS'($urandom_range(300, 0)),
                         $urandom_range(4) == 0);
         end
         seq_count++;
      end

      // --- end: drain, then watch for stray results ---
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
